/* sv/bia_pkg.sv */
package bia_pkg;

   localparam int RID_W    = 12;
   localparam int STATUS_W = 2;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] RSP_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_INVALID = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HINT,
      S_SCAN,
      S_PICK,
      S_TAKE,
      S_REL_DIV,
      S_REL_CHK,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR_STEP,
      DP_LOAD_HINT,
      DP_LOAD_REL,
      DP_NEXT_WORD,
      DP_USE_HINT,
      DP_PICK,
      DP_TAKE,
      DP_REL_LOCATE,
      DP_REL_FREE,
      DP_FAIL_ALLOC,
      DP_FAIL_REL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hint_oob;
      logic hint_free;
      logic word_free;
      logic last_word;
      logic rid_valid;
      logic bit_used;
   } dp_status_type;

endpackage

/* sv/bia_datapath.sv */
module bia_datapath #(
   parameter int WORD_BITS = 32,
   parameter int NUM_WORDS = 128,
   parameter int MIN_ID    = 300,
   parameter int MAX_ID    = 4095
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bia_pkg::dp_cmd_type                cmd,
   input  logic [bia_pkg::RID_W-1:0]          req_release_id,
   output bia_pkg::dp_status_type             status,
   output logic [bia_pkg::RID_W-1:0]          rsp_result_id,
   output logic [bia_pkg::STATUS_W-1:0]       rsp_status
);
   import bia_pkg::*;

   localparam int CAP        = NUM_WORDS * WORD_BITS;
   localparam int TOP        = (MAX_ID < CAP - 1) ? MAX_ID : CAP - 1;
   localparam int ID_W       = $clog2(CAP + 1);
   localparam int HMAX       = (CAP > MIN_ID) ? CAP : MIN_ID;
   localparam int HW         = $clog2(HMAX + 1);
   localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int RECIP      = (1 << RID_W) / WORD_BITS;
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int PW         = RID_W + RECIP_W;
   localparam bit HINT_OOB0  = (MIN_ID >= CAP);
   localparam int HINT_WORD0 = HINT_OOB0 ? 0 : MIN_ID / WORD_BITS;
   localparam int HINT_OFF0  = MIN_ID % WORD_BITS;

   // bitmap: a set bit is taken; bits outside the id range are set by the clear pass
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [AW-1:0]             addr_ff, addr_in;
   logic [ID_W-1:0]           base_ff, base_in;
   logic [OFF_W-1:0]          off_ff, off_in;
   logic [HW-1:0]             hint_id_ff, hint_id_in;
   logic [AW-1:0]             hint_word_ff, hint_word_in;
   logic [OFF_W-1:0]          hint_off_ff, hint_off_in;
   logic                      hint_oob_ff, hint_oob_in;
   logic [RID_W-1:0]          rid_ff, rid_in;
   logic [PW-1:0]             prod_ff, prod_in;
   logic [RID_W-1:0]          res_id_ff, res_id_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [RID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic                      wr_en;
   logic [WORD_BITS-1:0]      wr_data;
   logic [WORD_BITS-1:0]      clr_mask;
   logic [WORD_BITS-1:0]      off_bit;
   logic [OFF_W-1:0]          first_free;
   logic [RECIP_W-1:0]        q_est, q_fix;
   logic [RID_W-1:0]          q_base, r_est, r_fix;
   logic                      r_over;
   logic [ID_W-1:0]           id_full;
   logic                      wrap;
   logic                      last_word;
   logic                      rid_valid;

   assign last_word = (addr_ff == AW'(NUM_WORDS - 1));
   assign rid_valid = (rid_ff >= MIN_ID) && (rid_ff <= TOP);
   assign off_bit   = WORD_BITS'(1) << off_ff;
   assign id_full   = base_ff + ID_W'(off_ff);
   assign wrap      = (off_ff == OFF_W'(WORD_BITS - 1));

   // reciprocal estimate is low by at most one; one compare-subtract fixes it
   assign q_est  = prod_ff[PW-1:RID_W];
   assign q_base = RID_W'(q_est * WORD_BITS);
   assign r_est  = rid_ff - q_base;
   assign r_over = (r_est >= RID_W'(WORD_BITS));
   assign r_fix  = r_over ? r_est - RID_W'(WORD_BITS) : r_est;
   assign q_fix  = r_over ? q_est + 1'b1 : q_est;

   always_comb begin
      logic [ID_W:0] cid;
      cid = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         cid = {1'b0, base_ff} + (ID_W + 1)'(i);
         clr_mask[i] = (cid < MIN_ID) || (cid > TOP);
      end
   end

   always_comb begin
      first_free = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!rdata_ff[i]) begin
            first_free = OFF_W'(i);
         end
      end
   end

   always_comb begin
      addr_in       = addr_ff;
      base_in       = base_ff;
      off_in        = off_ff;
      hint_id_in    = hint_id_ff;
      hint_word_in  = hint_word_ff;
      hint_off_in   = hint_off_ff;
      hint_oob_in   = hint_oob_ff;
      rid_in        = rid_ff;
      prod_in       = prod_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_data       = rdata_ff;
      case (cmd.op)
         DP_CLEAR_STEP: begin
            wr_en   = 1'b1;
            wr_data = clr_mask;
            if (!last_word) begin
               addr_in = addr_ff + 1'b1;
               base_in = base_ff + ID_W'(WORD_BITS);
            end
         end
         DP_LOAD_HINT: begin
            addr_in = hint_word_ff;
            base_in = ID_W'(hint_id_ff - HW'(hint_off_ff));
         end
         DP_LOAD_REL: begin
            rid_in  = req_release_id;
            prod_in = PW'(req_release_id * RECIP);
         end
         DP_NEXT_WORD: begin
            addr_in = addr_ff + 1'b1;
            base_in = base_ff + ID_W'(WORD_BITS);
         end
         DP_USE_HINT: begin
            off_in = hint_off_ff;
         end
         DP_PICK: begin
            off_in = first_free;
         end
         DP_TAKE: begin
            wr_en         = 1'b1;
            wr_data       = rdata_ff | off_bit;
            res_id_in     = RID_W'(id_full);
            res_status_in = RSP_OK;
            hint_id_in    = HW'(id_full) + HW'(1);
            hint_off_in   = wrap ? '0 : off_ff + 1'b1;
            hint_word_in  = wrap ? addr_ff + 1'b1 : addr_ff;
            hint_oob_in   = wrap && last_word;
         end
         DP_REL_LOCATE: begin
            addr_in = AW'(q_fix);
            off_in  = OFF_W'(r_fix);
            base_in = ID_W'(rid_ff - r_fix);
         end
         DP_REL_FREE: begin
            wr_en         = 1'b1;
            wr_data       = rdata_ff & ~off_bit;
            res_id_in     = rid_ff;
            res_status_in = RSP_OK;
            if (hint_id_ff > rid_ff) begin
               hint_id_in   = HW'(rid_ff);
               hint_word_in = addr_ff;
               hint_off_in  = off_ff;
               hint_oob_in  = 1'b0;
            end
         end
         DP_FAIL_ALLOC: begin
            res_id_in     = '0;
            res_status_in = RSP_NO_FREE;
         end
         DP_FAIL_REL: begin
            res_id_in     = rid_ff;
            res_status_in = RSP_INVALID;
         end
         default: begin
         end
      endcase
   end

   assign rsp_id_in     = cmd.rsp_load ? res_id_ff : rsp_id_ff;
   assign rsp_status_in = cmd.rsp_load ? res_status_ff : rsp_status_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
      rdata_ff <= mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         base_ff      <= '0;
         hint_id_ff   <= HW'(MIN_ID);
         hint_word_ff <= AW'(HINT_WORD0);
         hint_off_ff  <= OFF_W'(HINT_OFF0);
         hint_oob_ff  <= HINT_OOB0;
      end else begin
         addr_ff      <= addr_in;
         base_ff      <= base_in;
         hint_id_ff   <= hint_id_in;
         hint_word_ff <= hint_word_in;
         hint_off_ff  <= hint_off_in;
         hint_oob_ff  <= hint_oob_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff        <= off_in;
      rid_ff        <= rid_in;
      prod_ff       <= prod_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign status.clear_last = last_word;
   assign status.hint_oob   = hint_oob_ff;
   assign status.hint_free  = !rdata_ff[hint_off_ff];
   assign status.word_free  = !(&rdata_ff);
   assign status.last_word  = last_word;
   assign status.rid_valid  = rid_valid;
   assign status.bit_used   = rdata_ff[off_ff];

   assign rsp_result_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* sv/bia_ctrl.sv */
module bia_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bia_pkg::dp_status_type status,
   output bia_pkg::dp_cmd_type    cmd
);
   import bia_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_RELEASE) begin
                  state_in = S_REL_DIV;
               end else if (status.hint_oob) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_HINT;
               end
            end
         end
         S_HINT: begin
            if (status.hint_free) begin
               state_in = S_TAKE;
            end else if (status.word_free) begin
               state_in = S_PICK;
            end else if (status.last_word) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.word_free) begin
               state_in = S_PICK;
            end else if (status.last_word) begin
               state_in = S_DONE;
            end
         end
         S_PICK:    state_in = S_TAKE;
         S_TAKE:    state_in = S_DONE;
         S_REL_DIV: state_in = status.rid_valid ? S_REL_CHK : S_DONE;
         S_REL_CHK: state_in = S_DONE;
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd.op       = DP_NOP;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         S_CLEAR: cmd.op = DP_CLEAR_STEP;
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_RELEASE) begin
                  cmd.op = DP_LOAD_REL;
               end else if (status.hint_oob) begin
                  cmd.op = DP_FAIL_ALLOC;
               end else begin
                  cmd.op = DP_LOAD_HINT;
               end
            end
         end
         S_HINT: begin
            if (status.hint_free) begin
               cmd.op = DP_USE_HINT;
            end else if (status.word_free) begin
               cmd.op = DP_NOP;
            end else if (status.last_word) begin
               cmd.op = DP_FAIL_ALLOC;
            end else begin
               cmd.op = DP_NEXT_WORD;
            end
         end
         S_SCAN: begin
            if (status.word_free) begin
               cmd.op = DP_NOP;
            end else if (status.last_word) begin
               cmd.op = DP_FAIL_ALLOC;
            end else begin
               cmd.op = DP_NEXT_WORD;
            end
         end
         S_PICK:    cmd.op = DP_PICK;
         S_TAKE:    cmd.op = DP_TAKE;
         S_REL_DIV: cmd.op = status.rid_valid ? DP_REL_LOCATE : DP_FAIL_REL;
         S_REL_CHK: cmd.op = status.bit_used ? DP_REL_FREE : DP_FAIL_REL;
         S_DONE:    cmd.rsp_load = slot_free;
         default:   cmd.op = DP_NOP;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/bitmap_id_allocator_unit.sv */
// Next-fit identifier allocator over a word-organised bitmap.
// Request channel (req_): req_action 0 allocates, 1 releases req_release_id.
// Response channel (rsp_): one beat per request, rsp_result_id and rsp_status
// (0 ok, 1 nothing free, 2 release of a free or out-of-range id, ignored).
// One request is in flight at a time; the block reads one bitmap word per
// cycle from a RAM with one write and one read port. An allocate is quickest
// when the hint is free and otherwise scans the words beyond the hint word;
// a failed scan and an allocate with the hint past the bitmap end early, as
// does a release of an out-of-range id. req_ready rises together with
// rsp_valid.
// After reset a clearing pass writes every bitmap word, marking ids outside
// MIN_ID..MAX_ID as taken; req_ready stays low meanwhile.
// The response sits in an output register: a new request is taken while it
// waits, but its own response is held back until the waiting beat is taken.
module bitmap_id_allocator_unit #(
   parameter int WORD_BITS = 32,
   parameter int NUM_WORDS = 128,
   parameter int MIN_ID    = 300,
   parameter int MAX_ID    = 4095
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [bia_pkg::RID_W-1:0]    req_release_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bia_pkg::RID_W-1:0]    rsp_result_id,
   output logic [bia_pkg::STATUS_W-1:0] rsp_status
);
   import bia_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   bia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   bia_datapath #(
      .WORD_BITS (WORD_BITS),
      .NUM_WORDS (NUM_WORDS),
      .MIN_ID    (MIN_ID),
      .MAX_ID    (MAX_ID)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_release_id (req_release_id),
      .status         (status),
      .rsp_result_id  (rsp_result_id),
      .rsp_status     (rsp_status)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   import bia_pkg::*;

   localparam int WORD_BITS = 32;
   localparam int NUM_WORDS = 128;
   localparam int MIN_ID    = 300;
   localparam int MAX_ID    = 4095;
   localparam int LAST_BIT  = NUM_WORDS * WORD_BITS - 1;
   localparam int TOP_ID    = (MAX_ID < LAST_BIT) ? MAX_ID : LAST_BIT;
   localparam int NUM_IDS   = TOP_ID - MIN_ID + 1;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [RID_W-1:0]    id;
      logic [STATUS_W-1:0] status;
   } id_resp_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_action     = ACT_ALLOC;
   logic [RID_W-1:0]    req_release_id = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [RID_W-1:0]    rsp_result_id;
   logic [STATUS_W-1:0] rsp_status;

   // allocator state as predicted
   logic [WORD_BITS-1:0] used_map [NUM_WORDS];
   int unsigned          free_cnt [NUM_WORDS];
   logic [12:0]          search_hint;

   id_resp_type expected_resps[$];
   int          errors = 0;
   int unsigned burst_left = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned rx_mode = 0;
   int unsigned rx_left = 0;
   logic        rx_toggle = 1'b0;

   bitmap_id_allocator_unit #(
      .WORD_BITS(WORD_BITS),
      .NUM_WORDS(NUM_WORDS),
      .MIN_ID   (MIN_ID),
      .MAX_ID   (MAX_ID)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_release_id(req_release_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result_id (rsp_result_id),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic id_in_range(int unsigned id);
      return id >= MIN_ID && id <= TOP_ID;
   endfunction

   function automatic void reset_allocator_model();
      int lo;
      int hi;
      for (int w = 0; w < NUM_WORDS; w++) begin
         used_map[w] = '0;
         lo = w * WORD_BITS;
         hi = lo + WORD_BITS - 1;
         if (lo < MIN_ID) lo = MIN_ID;
         if (hi > TOP_ID) hi = TOP_ID;
         free_cnt[w] = (lo <= hi) ? hi - lo + 1 : 0;
      end
      search_hint = 13'(MIN_ID);
   endfunction

   function automatic void allocator_predict(input logic act, input logic [RID_W-1:0] rid,
                                             output id_resp_type resp);
      int unsigned h;
      int unsigned w;
      int unsigned off;
      int unsigned cand;
      logic        found;
      resp.id     = rid;
      resp.status = RSP_OK;
      found       = 1'b0;
      cand        = 0;
      if (act == ACT_ALLOC) begin
         h = search_hint;
         if (id_in_range(h) && !used_map[h / WORD_BITS][h % WORD_BITS]) begin
            cand  = h;
            found = 1'b1;
         end else begin
            // next fit: first word with a free bit from the hint's word up, no wrap
            for (w = h / WORD_BITS; w < NUM_WORDS && !found; w++) begin
               if (free_cnt[w] != 0) begin
                  for (off = 0; off < WORD_BITS && !found; off++) begin
                     cand = w * WORD_BITS + off;
                     if (id_in_range(cand) && !used_map[w][off]) found = 1'b1;
                  end
               end
            end
         end
         if (found) begin
            used_map[cand / WORD_BITS][cand % WORD_BITS] = 1'b1;
            if (free_cnt[cand / WORD_BITS] > 0) free_cnt[cand / WORD_BITS]--;
            search_hint = 13'(cand + 1);
            resp.id     = RID_W'(cand);
         end else begin
            resp.id     = '0;
            resp.status = RSP_NO_FREE;
         end
      end else if (!id_in_range(rid) || !used_map[rid / WORD_BITS][rid % WORD_BITS]) begin
         resp.status = RSP_INVALID;
      end else begin
         used_map[rid / WORD_BITS][rid % WORD_BITS] = 1'b0;
         free_cnt[rid / WORD_BITS]++;
         if (search_hint > rid) search_hint = 13'(rid);
      end
   endfunction

   // some id currently held, starting from a random point
   function automatic logic [RID_W-1:0] pick_used_id();
      int unsigned start;
      int unsigned id;
      start = $urandom_range(MIN_ID, TOP_ID);
      for (int unsigned k = 0; k < NUM_IDS; k++) begin
         id = MIN_ID + (start - MIN_ID + k) % NUM_IDS;
         if (used_map[id / WORD_BITS][id % WORD_BITS]) return RID_W'(id);
      end
      return RID_W'(start);
   endfunction

   task automatic send_request(input logic act, input logic [RID_W-1:0] rid,
                               output id_resp_type resp);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_release_id <= rid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      allocator_predict(act, rid, resp);
      expected_resps.push_back(resp);
   endtask

   task automatic random_request(input int unsigned alloc_pct);
      id_resp_type resp;
      if ($urandom_range(0, 99) < alloc_pct)
         send_request(ACT_ALLOC, RID_W'($urandom), resp);
      else if ($urandom_range(0, 4) != 0)
         send_request(ACT_RELEASE, pick_used_id(), resp);
      else if ($urandom_range(0, 2) == 0)
         send_request(ACT_RELEASE, RID_W'($urandom_range(0, MIN_ID - 1)), resp);
      else
         send_request(ACT_RELEASE, RID_W'($urandom), resp);
   endtask

   task automatic test_directed();
      id_resp_type resp;
      send_request(ACT_ALLOC, '0, resp);
      send_request(ACT_ALLOC, '1, resp);
      send_request(ACT_ALLOC, '0, resp);
      send_request(ACT_RELEASE, RID_W'(MIN_ID + 1), resp);
      send_request(ACT_RELEASE, RID_W'(MIN_ID + 1), resp);   // already free
      send_request(ACT_ALLOC, '0, resp);                      // hint free again
      send_request(ACT_ALLOC, '0, resp);                      // hint taken, scan in word
      send_request(ACT_RELEASE, '0, resp);
      send_request(ACT_RELEASE, RID_W'(MIN_ID - 1), resp);
      send_request(ACT_RELEASE, RID_W'(MIN_ID), resp);
      send_request(ACT_RELEASE, RID_W'(TOP_ID), resp);
      send_request(ACT_RELEASE, 12'hAAA, resp);
      send_request(ACT_RELEASE, 12'h555, resp);
      send_request(ACT_ALLOC, 12'h555, resp);
      send_request(ACT_RELEASE, RID_W'(MIN_ID + 3), resp);
      send_request(ACT_ALLOC, 12'hAAA, resp);
      send_request(ACT_ALLOC, '0, resp);
   endtask

   task automatic test_random_mix();
      int unsigned alloc_pct;
      for (int epoch = 0; epoch < 5; epoch++) begin
         case ($urandom_range(0, 3))
            0: begin
               alloc_pct = 40;
            end
            1: begin
               alloc_pct = 55;
            end
            2: begin
               alloc_pct = 70;
            end
            default: begin
               alloc_pct = 85;
            end
         endcase
         repeat (250) random_request(alloc_pct);
      end
   endtask

   // receiver holds off while requests keep coming, so the input must stall
   task automatic test_backpressure();
      hold_requests++;
      repeat (16) random_request(60);
   endtask

   // long allocate run, then holes punched below the hint and refilled by scans
   task automatic test_dense_run();
      id_resp_type resp;
      repeat (150) send_request(ACT_ALLOC, RID_W'($urandom), resp);
      repeat (40) send_request(ACT_RELEASE, pick_used_id(), resp);
      repeat (40) send_request(ACT_ALLOC, '0, resp);
      repeat (30) random_request(50);
   endtask

   // receiver: changing stall patterns plus the occasional long hold
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(16, 160);
      end else begin
         rx_left--;
      end
      rx_toggle = ~rx_toggle;
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= $urandom_range(0, 1);
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready <= rx_toggle;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      id_resp_type exp_resp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_resps.size() == 0) begin
            errors++;
            $display("%0t: beat with nothing expected: id %0d status %0d", $time,
                     rsp_result_id, rsp_status);
         end else begin
            exp_resp = expected_resps.pop_front();
            if (rsp_result_id !== exp_resp.id) begin
               errors++;
               $display("%0t: result_id expected %0d actual %0d", $time, exp_resp.id,
                        rsp_result_id);
            end
            if (rsp_status !== exp_resp.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, exp_resp.status,
                        rsp_status);
            end
         end
      end
   end

   initial begin
      reset_allocator_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix();
      test_backpressure();
      test_dense_run();
      req_valid <= 1'b0;
      while (expected_resps.size() != 0) @(posedge clock);
      repeat (NUM_WORDS + 8) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* bitmap_id_allocator_unit.f */
sv/bia_pkg.sv
sv/bia_datapath.sv
sv/bia_ctrl.sv
sv/bitmap_id_allocator_unit.sv
dv/testbench.sv
